@@ rtl/mmf_pkg.sv @@
// Package for the moving median filter: window size, field widths, types and
// the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package mmf_pkg;

  localparam int WINDOW         = 8;
  localparam int SAMPLE_W       = 24;
  localparam int HELD_W         = 4;
  localparam int DEADBAND_W     = 10;
  localparam int DEADBAND_RESET = 10;

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [PTR_W-1:0]           ptr_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [DEADBAND_W-1:0]      deadband_t;
  typedef logic [HELD_W-1:0]          held_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/mmf_datapath.sv @@
// Datapath of the moving median filter: deadband, ring window, rank counting
// and the output word register. Depends on mmf_pkg.
`default_nettype none

module mmf_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  mmf_pkg::deadband_t       cfg_wdata_i,
  input  mmf_pkg::sample_t         sample_i,
  input  logic                     ready_req_i,
  input  mmf_pkg::cmd_t            cmd_i,
  output mmf_pkg::status_t         status_o,
  output mmf_pkg::sample_t         median_o,
  output mmf_pkg::held_t           held_count_o
);
  import mmf_pkg::*;

  deadband_t deadband_q;
  sample_t   lanes_q [WINDOW];
  ptr_t      wp_q, wp_d;
  cnt_t      fill_q, fill_d;
  ptr_t      cand_q;
  sample_t   median_q;
  sample_t   out_median_q;
  held_t     out_count_q;

  logic [SAMPLE_W-1:0] mag;
  logic                below;
  logic                do_write;
  sample_t             wr_value;

  sample_t           cand;
  logic [WINDOW-1:0] lt_vec, le_vec;
  cnt_t              n_lt, n_le, k_rank, fill_m1;
  logic              match;

  always_comb begin
    mag      = sample_i[SAMPLE_W-1] ? (~sample_i + 1'b1) : sample_i;
    below    = mag < {{(SAMPLE_W-DEADBAND_W){1'b0}}, deadband_q};
    wr_value = below ? '0 : sample_i;
    do_write = ready_req_i && !(sample_i[SAMPLE_W-1] && !below);
    wp_d     = (wp_q == ptr_t'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
    fill_d   = (fill_q == cnt_t'(WINDOW)) ? fill_q : fill_q + 1'b1;
  end

  always_comb begin
    cand    = lanes_q[cand_q];
    fill_m1 = fill_q - cnt_t'(1);
    k_rank  = fill_m1 >> 1;
    for (int j = 0; j < WINDOW; j++) begin
      lt_vec[j] = (cnt_t'(j) < fill_q) && (lanes_q[j] < cand);
      le_vec[j] = (cnt_t'(j) < fill_q) && (lanes_q[j] <= cand);
    end
    n_lt  = cnt_t'($countones(lt_vec));
    n_le  = cnt_t'($countones(le_vec));
    match = (fill_q != '0) && (n_lt <= k_rank) && (n_le > k_rank);
    status_o.scan_last = (fill_q == '0) || (cnt_t'(cand_q) == fill_m1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= deadband_t'(DEADBAND_RESET);
      wp_q       <= '0;
      fill_q     <= '0;
      cand_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        deadband_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        cand_q <= '0;
        if (do_write) begin
          wp_q   <= wp_d;
          fill_q <= fill_d;
        end
      end else if (cmd_i.scan) begin
        cand_q <= cand_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      median_q <= '0;
      if (do_write) begin
        lanes_q[wp_q] <= wr_value;
      end
    end else if (cmd_i.scan && match) begin
      median_q <= cand;
    end
    if (cmd_i.load) begin
      out_median_q <= median_q;
      out_count_q  <= held_t'(fill_q);
    end
  end

  assign median_o     = out_median_q;
  assign held_count_o = out_count_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cnt_t'(WINDOW))
    else $error("fill count above window size");

  a_fill_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> fill_q >= $past(fill_q))
    else $error("fill count decreased");

  a_ptr_tracks_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < cnt_t'(WINDOW) |-> cnt_t'(wp_q) == fill_q)
    else $error("write pointer out of step with fill count");

endmodule

`default_nettype wire

@@ rtl/mmf_ctrl.sv @@
// Controller of the moving median filter: sequences accept, rank scan and
// output load, and owns the output valid. Depends on mmf_pkg.
`default_nettype none

module mmf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  mmf_pkg::status_t  status_i,
  output mmf_pkg::cmd_t     cmd_o
);
  import mmf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  always_comb begin
    state_d      = state_q;
    out_free     = !out_valid_q || !out_stall_i;
    out_valid_d  = out_valid_q && out_stall_i;
    cmd_o        = '0;
    in_stall_o   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == ST_SCAN)
    else $error("accepted word did not start a scan");

  a_fin_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && !out_free |=> state_q == ST_FIN && out_valid_q)
    else $error("result left before output register freed");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> out_valid_q && state_q == ST_IDLE)
    else $error("load did not present a word");

endmodule

`default_nettype wire

@@ rtl/moving_median_filter.sv @@
// Top level of the moving median filter: controller plus datapath.
// Depends on mmf_pkg, mmf_ctrl and mmf_datapath.
//
// One input word is taken, then the block scans the held window one
// candidate per cycle, counting in parallel how many held samples lie below
// and at or below it, and picks the one of rank (count-1)/2. The finished
// result sits in an output register, so the next word can be taken while it
// waits; a new result waits while that register stays stalled. Readings with
// magnitude below the deadband register become zero; negative readings at or
// above the deadband and not-ready readings are not stored but still produce
// a result. An empty window reports median 0.
`default_nettype none

module moving_median_filter (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  mmf_pkg::deadband_t     cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  mmf_pkg::sample_t       sample_i,
  input  logic                   ready_req_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output mmf_pkg::sample_t       median_o,
  output mmf_pkg::held_t         held_count_o
);
  import mmf_pkg::*;

  cmd_t    cmd;
  status_t status;

  mmf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mmf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sample_i     (sample_i),
    .ready_req_i  (ready_req_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .median_o     (median_o),
    .held_count_o (held_count_o)
  );

endmodule

`default_nettype wire
